// ----- hw/rtl/lwpb_pkg.sv -----
// Package for the LRU write-back page buffer manager.
// Holds the item types, the controller-to-datapath command struct and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package lwpb_pkg;

    localparam int NUM_SLOTS    = 8;
    localparam int BLOCK_BITS   = 9;
    localparam int ADDRESS_BITS = 24;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int BLK_W        = ADDRESS_BITS - BLOCK_BITS;
    localparam int HW_W         = BLK_W + 1;

    typedef struct packed {
        logic                    command;
        logic [ADDRESS_BITS-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [BLOCK_BITS-1:0] offset;
        logic                  hit;
        logic                  write_back;
        logic [BLK_W-1:0]      write_back_block;
        logic                  fill;
    } t_out_item;

    typedef struct packed {
        logic lookup;
        logic update;
    } t_dp_cmd;

endpackage

// ----- hw/rtl/lwpb_ctrl.sv -----
// Controller for the LRU write-back page buffer manager.
// Sequences the lookup and update steps of one item; depends on lwpb_pkg.
`timescale 1ns / 1ps

module lwpb_ctrl
    import lwpb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    output logic    o_result_valid
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_result_valid;
    logic   n_result_valid;

    always_comb begin
        n_state        = r_state;
        n_result_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state        = S_IDLE;
                n_result_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
        end
    end

    assign busy           = (r_state == S_UPDATE);
    assign o_cmd.lookup   = start && (r_state == S_IDLE);
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_result_valid = r_result_valid;

endmodule

// ----- hw/rtl/lwpb_datapath.sv -----
// Datapath for the LRU write-back page buffer manager.
// Holds slot tags, valid, dirty, recency ranks and the high-water mark; depends on lwpb_pkg.
`timescale 1ns / 1ps

module lwpb_datapath
    import lwpb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    // Slot state.
    logic [BLK_W-1:0]  r_block [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [SLOT_W-1:0] r_rank  [NUM_SLOTS];
    logic [HW_W-1:0]   r_hw;

    // Lookup results held for the update cycle.
    logic                  r_is_write;
    logic [BLK_W-1:0]      r_blk;
    logic [BLOCK_BITS-1:0] r_ofs;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_sel;
    logic [SLOT_W-1:0]     r_sel_rank;
    logic                  r_wb;
    logic [BLK_W-1:0]      r_wb_blk;

    t_out_item r_result;

    logic [BLK_W-1:0]      n_blk;
    logic                  n_hit;
    logic [SLOT_W-1:0]     n_hit_slot;
    logic [SLOT_W-1:0]     n_lru_slot;
    logic [SLOT_W-1:0]     n_sel;
    logic                  n_wb;
    logic [HW_W-1:0]       n_hw;
    logic                  n_fill;

    assign n_blk = i_item.address[ADDRESS_BITS-1:BLOCK_BITS];

    // A block is resident in at most one valid slot, so any match will do.
    always_comb begin
        n_hit      = 1'b0;
        n_hit_slot = '0;
        n_lru_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_valid[i] && (r_block[i] == n_blk)) begin
                n_hit      = 1'b1;
                n_hit_slot = SLOT_W'(i);
            end
            if (r_rank[i] == SLOT_W'(NUM_SLOTS - 1)) begin
                n_lru_slot = SLOT_W'(i);
            end
        end
        n_sel = n_hit ? n_hit_slot : n_lru_slot;
        n_wb  = !n_hit && r_valid[n_lru_slot] && r_dirty[n_lru_slot];
    end

    // The mark is raised before the fill decision of the same item.
    always_comb begin
        n_hw = r_hw;
        if (r_wb && ({1'b0, r_wb_blk} >= r_hw)) begin
            n_hw = {1'b0, r_wb_blk} + HW_W'(1);
        end
        n_fill = !r_hit && ({1'b0, r_blk} < n_hw);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_is_write <= i_item.command;
            r_blk      <= n_blk;
            r_ofs      <= i_item.address[BLOCK_BITS-1:0];
            r_hit      <= n_hit;
            r_sel      <= n_sel;
            r_sel_rank <= r_rank[n_sel];
            r_wb       <= n_wb;
            r_wb_blk   <= n_wb ? r_block[n_lru_slot] : '0;
        end
        if (i_cmd.update) begin
            if (!r_hit) begin
                r_block[r_sel] <= r_blk;
            end
            r_result.slot             <= r_sel;
            r_result.offset           <= r_ofs;
            r_result.hit              <= r_hit;
            r_result.write_back       <= r_wb;
            r_result.write_back_block <= r_wb_blk;
            r_result.fill             <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_hw    <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rank[i] <= SLOT_W'(i);
            end
        end else if (i_cmd.update) begin
            r_hw           <= n_hw;
            r_valid[r_sel] <= 1'b1;
            // A taken slot was either clean or is written back now.
            r_dirty[r_sel] <= r_is_write || (r_hit && r_dirty[r_sel]);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (SLOT_W'(i) == r_sel) begin
                    r_rank[i] <= '0;
                end else if (r_rank[i] < r_sel_rank) begin
                    r_rank[i] <= r_rank[i] + SLOT_W'(1);
                end
            end
        end
    end

    assign o_result = r_result;

endmodule

// ----- hw/rtl/lru_writeback_page_buffer.sv -----
// The result strobe is registered in the result-valid register after the S_UPDATE state.
// Items are taken one at a time: the tag compare at acceptance, then the slot state
// update while busy, when start is ignored; the receiver cannot stall.
// Reset clears slot valid and dirty bits, the recency order and the high-water mark
// at once; slot tags are not cleared and no clearing pass is needed.
// Top level; instantiates lwpb_ctrl and lwpb_datapath, depends on lwpb_pkg.
`timescale 1ns / 1ps

module lru_writeback_page_buffer
    import lwpb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_result_valid,
    output t_out_item o_result
);

    t_dp_cmd w_cmd;

    lwpb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_cmd          (w_cmd),
        .o_result_valid (o_result_valid)
    );

    lwpb_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
